// ===== src/mbrx_pkg.sv =====
// shared types, constants and crc table for the modbus reply receiver
`timescale 1ns / 1ps

package mbrx_pkg;

    localparam int unsigned PADDR_W = 3;

    localparam logic [PADDR_W-1:0] REG_SLAVE_ADDRESS     = 3'd0;
    localparam logic [PADDR_W-1:0] REG_EXPECTED_FUNCTION = 3'd4;

    localparam logic [7:0]  SLAVE_ADDRESS_RST     = 8'h01;
    localparam logic [7:0]  EXPECTED_FUNCTION_RST = 8'h03;
    localparam logic [7:0]  BYTE_COUNT_EXPECTED   = 8'h04;
    localparam logic [15:0] CRC_INIT              = 16'hFFFF;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_BUSY = 2'd1,
        ST_FAIL = 2'd2,
        ST_DONE = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] slave_address;
        logic [7:0] expected_function;
    } t_cfg;

    // crc-16/modbus nibble table, reflected polynomial 0xA001
    function automatic logic [15:0] crc_nib(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'h0: v = 16'h0000;
            4'h1: v = 16'hCC01;
            4'h2: v = 16'hD801;
            4'h3: v = 16'h1400;
            4'h4: v = 16'hF001;
            4'h5: v = 16'h3C00;
            4'h6: v = 16'h2800;
            4'h7: v = 16'hE401;
            4'h8: v = 16'hA001;
            4'h9: v = 16'h6C00;
            4'hA: v = 16'h7800;
            4'hB: v = 16'hB401;
            4'hC: v = 16'h5000;
            4'hD: v = 16'h9C01;
            4'hE: v = 16'h8801;
            4'hF: v = 16'h4400;
            default: v = 16'h0000;
        endcase
        return v;
    endfunction

endpackage

// ===== src/mbrx_crc.sv =====
// crc-16/modbus update by one byte, two nibble table lookups
`timescale 1ns / 1ps

module mbrx_crc (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import mbrx_pkg::*;

    logic [15:0] w_mid;

    // low nibble first, then high nibble
    assign w_mid = crc_nib(i_byte[3:0] ^ i_crc[3:0]) ^ {4'h0, i_crc[15:4]};
    assign o_crc = crc_nib(i_byte[7:4] ^ w_mid[3:0]) ^ {4'h0, w_mid[15:4]};

endmodule

// ===== src/mbrx_cfg.sv =====
// apb register file: slave address and expected function code
`timescale 1ns / 1ps

module mbrx_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbrx_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output mbrx_pkg::t_cfg              o_cfg
);
    import mbrx_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.slave_address     <= SLAVE_ADDRESS_RST;
            r_cfg.expected_function <= EXPECTED_FUNCTION_RST;
        end else if (w_wr) begin
            if (paddr == REG_SLAVE_ADDRESS) begin
                r_cfg.slave_address <= pwdata[7:0];
            end
            if (paddr == REG_EXPECTED_FUNCTION) begin
                r_cfg.expected_function <= pwdata[7:0];
            end
        end
    end

    always_comb begin
        prdata = 32'h0;
        if (paddr == REG_SLAVE_ADDRESS) begin
            prdata = {24'h0, r_cfg.slave_address};
        end else if (paddr == REG_EXPECTED_FUNCTION) begin
            prdata = {24'h0, r_cfg.expected_function};
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/mbrx_frame.sv =====
// frame tracker: byte position, running crc, payload capture and result register
`timescale 1ns / 1ps

module mbrx_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbrx_pkg::t_cfg      i_cfg,
    input  logic                i_in_valid,
    input  logic [7:0]          i_in_byte,
    input  logic                i_res_stall,
    output logic                o_out_free,
    output logic                o_res_valid,
    output logic [1:0]          o_frame_status,
    output logic [15:0]         o_first_word,
    output logic signed [15:0]  o_second_word_tenths
);
    import mbrx_pkg::*;

    typedef enum logic [8:0] {
        S_ADDR   = 9'b000000001,
        S_FUNC   = 9'b000000010,
        S_COUNT  = 9'b000000100,
        S_DATA0  = 9'b000001000,
        S_DATA1  = 9'b000010000,
        S_DATA2  = 9'b000100000,
        S_DATA3  = 9'b001000000,
        S_CRC_LO = 9'b010000000,
        S_CRC_HI = 9'b100000000
    } t_state;

    t_state      r_state, n_state;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_pay [4];
    logic [7:0]  r_crc_lo;

    logic        r_out_valid;
    t_status     r_status, n_status;
    logic [15:0] r_first, n_first;
    logic [15:0] r_second, n_second;

    logic        w_take;
    logic [15:0] w_crc_in, w_crc_new;

    assign o_out_free = !r_out_valid || !i_res_stall;
    assign w_take     = i_in_valid && o_out_free;

    // first byte always starts from the initial value
    assign w_crc_in = (r_state == S_ADDR) ? CRC_INIT : r_crc;

    mbrx_crc u_crc (
        .i_crc  (w_crc_in),
        .i_byte (i_in_byte),
        .o_crc  (w_crc_new)
    );

    always_comb begin
        n_state  = r_state;
        n_crc    = r_crc;
        n_status = ST_BUSY;
        n_first  = 16'h0;
        n_second = 16'h0;
        case (r_state)
            S_FUNC: begin
                if (i_in_byte != i_cfg.expected_function) begin
                    n_status = ST_FAIL;
                    n_state  = S_ADDR;
                    n_crc    = CRC_INIT;
                end else begin
                    n_crc   = w_crc_new;
                    n_state = S_COUNT;
                end
            end
            S_COUNT: begin
                if (i_in_byte != BYTE_COUNT_EXPECTED) begin
                    n_status = ST_FAIL;
                    n_state  = S_ADDR;
                    n_crc    = CRC_INIT;
                end else begin
                    n_crc   = w_crc_new;
                    n_state = S_DATA0;
                end
            end
            S_DATA0: begin
                n_crc   = w_crc_new;
                n_state = S_DATA1;
            end
            S_DATA1: begin
                n_crc   = w_crc_new;
                n_state = S_DATA2;
            end
            S_DATA2: begin
                n_crc   = w_crc_new;
                n_state = S_DATA3;
            end
            S_DATA3: begin
                n_crc   = w_crc_new;
                n_state = S_CRC_LO;
            end
            S_CRC_LO: begin
                n_state = S_CRC_HI;
            end
            S_CRC_HI: begin
                // received crc is sent low byte first
                if ({i_in_byte, r_crc_lo} == r_crc) begin
                    n_status = ST_DONE;
                    n_first  = {r_pay[2], r_pay[3]};
                    n_second = {r_pay[0], r_pay[1]};
                end else begin
                    n_status = ST_FAIL;
                end
                n_state = S_ADDR;
                n_crc   = CRC_INIT;
            end
            default: begin
                // address byte, also recovery from any unexpected code
                if (i_in_byte != i_cfg.slave_address) begin
                    n_status = ST_IDLE;
                    n_state  = S_ADDR;
                    n_crc    = CRC_INIT;
                end else begin
                    n_crc   = w_crc_new;
                    n_state = S_FUNC;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ADDR;
            r_crc   <= CRC_INIT;
        end else if (w_take) begin
            r_state <= n_state;
            r_crc   <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            case (r_state)
                S_DATA0:  r_pay[0] <= i_in_byte;
                S_DATA1:  r_pay[1] <= i_in_byte;
                S_DATA2:  r_pay[2] <= i_in_byte;
                S_DATA3:  r_pay[3] <= i_in_byte;
                S_CRC_LO: r_crc_lo <= i_in_byte;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_out_free) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status <= n_status;
            r_first  <= n_first;
            r_second <= n_second;
        end
    end

    assign o_res_valid          = r_out_valid;
    assign o_frame_status       = r_status;
    assign o_first_word         = r_first;
    assign o_second_word_tenths = r_second;

    a_words_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status != ST_DONE) |-> (r_first == 16'h0 && r_second == 16'h0))
        else $error("result words not zero on a non-finished transfer");

    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && (n_status == ST_FAIL || n_status == ST_DONE)) |=> (r_state == S_ADDR))
        else $error("frame end did not return to address position");

    a_idle_crc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADDR) |-> (r_crc == CRC_INIT))
        else $error("running crc not at initial value while idle");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_res_stall) |=> (r_out_valid && $stable(r_status)))
        else $error("stalled result changed");

endmodule

// ===== src/modbus_response_frame_receiver.sv =====
// Modbus RTU read reply receiver: an accepted byte passes the input register, then the
// result register; throughput one byte per cycle while no result stall holds it, set by the
// combinational frame position and crc update (two nibble table lookups) between them.
// Synchronous active-low reset empties both registers, returns to the address position
// with crc 0xFFFF and sets slave_address to 1 and expected_function to 3.
`timescale 1ns / 1ps

module modbus_response_frame_receiver (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rx_valid,
    output logic                        o_rx_stall,
    input  logic [7:0]                  i_rx_byte,
    output logic                        o_res_valid,
    input  logic                        i_res_stall,
    output logic [1:0]                  o_frame_status,
    output logic [15:0]                 o_first_word,
    output logic signed [15:0]          o_second_word_tenths,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mbrx_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mbrx_pkg::*;

    t_cfg       w_cfg;
    logic       w_out_free;
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    mbrx_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input stage holds while the result register cannot take its byte
    assign o_rx_stall = r_in_valid && !w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_rx_stall) begin
            r_in_valid <= i_rx_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx_valid && !o_rx_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    mbrx_frame u_frame (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg                (w_cfg),
        .i_in_valid           (r_in_valid),
        .i_in_byte            (r_in_byte),
        .i_res_stall          (i_res_stall),
        .o_out_free           (w_out_free),
        .o_res_valid          (o_res_valid),
        .o_frame_status       (o_frame_status),
        .o_first_word         (o_first_word),
        .o_second_word_tenths (o_second_word_tenths)
    );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the modbus read reply receiver
`timescale 1ns / 1ps

module tb;
    import mbrx_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int PHASE_COUNT    = 8;
    localparam int PHASE_ITEMS    = 140;
    localparam int DRAIN_CYCLES   = 4;
    localparam int FRAME_BYTES    = 9;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        t_status            status;
        logic [15:0]        first_word;
        logic signed [15:0] second_word;
    } t_reply_result;

    // bitwise crc-16/modbus, one byte
    function automatic logic [15:0] crc16_add_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ 16'hA001) : (r >> 1);
        end
        return r;
    endfunction

    class reply_predictor;
        logic [7:0]    slave_addr;
        logic [7:0]    exp_func;
        logic [3:0]    frame_pos;
        logic [15:0]   crc;
        logic [7:0]    data_bytes [4];
        logic [7:0]    crc_lo;
        t_reply_result pending_results [$];
        int            mismatch_count;

        function new();
            slave_addr     = SLAVE_ADDRESS_RST;
            exp_func       = EXPECTED_FUNCTION_RST;
            frame_pos      = '0;
            crc            = CRC_INIT;
            crc_lo         = '0;
            mismatch_count = 0;
            foreach (data_bytes[k]) data_bytes[k] = '0;
        endfunction

        function void set_reg(input logic [PADDR_W-1:0] a, input logic [7:0] v);
            if (a == REG_SLAVE_ADDRESS) begin
                slave_addr = v;
            end else if (a == REG_EXPECTED_FUNCTION) begin
                exp_func = v;
            end
        endfunction

        function void take_byte(input logic [7:0] b);
            t_reply_result r;
            logic [7:0]    want;
            r.status      = ST_BUSY;
            r.first_word  = '0;
            r.second_word = '0;
            if (frame_pos > 4'd8) frame_pos = '0;
            case (frame_pos)
                4'd0: begin
                    crc = CRC_INIT;
                    if (b != slave_addr) begin
                        r.status = ST_IDLE;
                    end else begin
                        crc       = crc16_add_byte(crc, b);
                        frame_pos = 4'd1;
                    end
                end
                4'd1, 4'd2: begin
                    want = (frame_pos == 4'd1) ? exp_func : BYTE_COUNT_EXPECTED;
                    if (b != want) begin
                        r.status  = ST_FAIL;
                        frame_pos = '0;
                        crc       = CRC_INIT;
                    end else begin
                        crc       = crc16_add_byte(crc, b);
                        frame_pos = frame_pos + 4'd1;
                    end
                end
                4'd3, 4'd4, 4'd5, 4'd6: begin
                    data_bytes[2'(frame_pos - 4'd3)] = b;
                    crc       = crc16_add_byte(crc, b);
                    frame_pos = frame_pos + 4'd1;
                end
                4'd7: begin
                    crc_lo    = b;
                    frame_pos = 4'd8;
                end
                default: begin
                    // received crc is low byte first
                    if ({b, crc_lo} == crc) begin
                        r.status      = ST_DONE;
                        r.first_word  = {data_bytes[2], data_bytes[3]};
                        r.second_word = {data_bytes[0], data_bytes[1]};
                    end else begin
                        r.status = ST_FAIL;
                    end
                    frame_pos = '0;
                    crc       = CRC_INIT;
                end
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(input logic [1:0] st, input logic [15:0] w1,
                                   input logic signed [15:0] w2);
            t_reply_result e;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected result: status %0d words %h %h", st, w1, w2);
            end else begin
                e = pending_results.pop_front();
                if (st !== e.status || w1 !== e.first_word || w2 !== e.second_word) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("mismatch: exp status %0d words %h %h, got %0d words %h %h",
                                 e.status, e.first_word, e.second_word, st, w1, w2);
                end
            end
        endfunction
    endclass

    logic                  i_clk                = 1'b0;
    logic                  i_rst_n              = 1'b0;
    logic                  i_rx_valid           = 1'b0;
    logic [7:0]            i_rx_byte            = '0;
    logic                  i_res_stall          = 1'b0;
    logic                  psel                 = 1'b0;
    logic                  penable              = 1'b0;
    logic                  pwrite               = 1'b0;
    logic [PADDR_W-1:0]    paddr                = '0;
    logic [31:0]           pwdata               = '0;
    logic                  o_rx_stall;
    logic                  o_res_valid;
    logic [1:0]            o_frame_status;
    logic [15:0]           o_first_word;
    logic signed [15:0]    o_second_word_tenths;
    logic [31:0]           prdata;
    logic                  pready;

    reply_predictor sb = new();
    int             cycle_count  = 0;
    bit             rx_idle_on   = 1'b1;
    bit             res_stall_on = 1'b1;
    logic [7:0]     cfg_addr     = SLAVE_ADDRESS_RST;
    logic [7:0]     cfg_func     = EXPECTED_FUNCTION_RST;

    modbus_response_frame_receiver DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_rx_valid           (i_rx_valid),
        .o_rx_stall           (o_rx_stall),
        .i_rx_byte            (i_rx_byte),
        .o_res_valid          (o_res_valid),
        .i_res_stall          (i_res_stall),
        .o_frame_status       (o_frame_status),
        .o_first_word         (o_first_word),
        .o_second_word_tenths (o_second_word_tenths),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // both channels are observed here, values sampled before the edge updates
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n) begin
            if (i_rx_valid && !o_rx_stall) sb.take_byte(i_rx_byte);
            if (o_res_valid && !i_res_stall)
                sb.check_result(o_frame_status, o_first_word, o_second_word_tenths);
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (res_stall_on && $urandom_range(0, 3) == 0) begin
                i_res_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_res_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            i_rx_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_rx_stall);
    endtask

    // one edge first so the last accepted transfer is already noted
    task automatic wait_drained();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [7:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= {24'h0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(a, v);
        if (a == REG_SLAVE_ADDRESS) cfg_addr = v;
        else cfg_func = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // builds a reply, crc over bytes 0..6, and sends its first n bytes
    task automatic send_reply(input logic [7:0] addr, input logic [7:0] func,
                              input logic [7:0] count, input logic [31:0] data,
                              input logic [15:0] crc_flip, input int n);
        logic [7:0]  fb [FRAME_BYTES];
        logic [15:0] c;
        fb[0] = addr;
        fb[1] = func;
        fb[2] = count;
        fb[3] = data[31:24];
        fb[4] = data[23:16];
        fb[5] = data[15:8];
        fb[6] = data[7:0];
        c = CRC_INIT;
        for (int k = 0; k < 7; k++) c = crc16_add_byte(c, fb[k]);
        c = c ^ crc_flip;
        fb[7] = c[7:0];
        fb[8] = c[15:8];
        for (int k = 0; k < n; k++) send_byte(fb[k]);
    endtask

    function automatic logic [7:0] pick_data();
        if ($urandom_range(0, 3) != 0) return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            default: return 8'h7F;
        endcase
    endfunction

    task automatic send_random_reply();
        int          kind;
        int          n;
        logic [7:0]  func;
        logic [7:0]  count;
        logic [15:0] flip;
        logic [31:0] data;
        kind  = $urandom_range(0, 9);
        n     = FRAME_BYTES;
        func  = cfg_func;
        count = BYTE_COUNT_EXPECTED;
        flip  = '0;
        data  = {pick_data(), pick_data(), pick_data(), pick_data()};
        case (kind)
            6: func  = func ^ 8'($urandom_range(1, 255));
            7: count = count ^ 8'($urandom_range(1, 255));
            8: flip  = 16'($urandom_range(1, 16'hFFFF));
            9: n     = $urandom_range(1, FRAME_BYTES - 1);
            default: ;
        endcase
        send_reply(cfg_addr, func, count, data, flip, n);
    endtask

    initial begin
        int         sent;
        logic [7:0] a;
        logic [7:0] f;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle byte, extreme words, header errors, bad crc
        send_byte(8'h00);
        send_reply(8'h01, 8'h03, BYTE_COUNT_EXPECTED, 32'h8000FFFF, 16'h0000, FRAME_BYTES);
        send_reply(8'h01, 8'h00, BYTE_COUNT_EXPECTED, 32'h0, 16'h0000, 2);
        send_reply(8'h01, 8'h03, 8'hFF, 32'h0, 16'h0000, 3);
        send_reply(8'h01, 8'h03, BYTE_COUNT_EXPECTED, 32'h7FFF0000, 16'h0001, FRAME_BYTES);
        // leave a frame open across the first register change
        send_byte(8'h01);
        wait_drained();

        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p)
                0: begin a = 8'h00; f = 8'hFF; end
                1: begin a = 8'hFF; f = 8'h00; end
                3: begin a = SLAVE_ADDRESS_RST; f = EXPECTED_FUNCTION_RST; end
                5: begin a = 8'($urandom_range(0, 255)); f = a; end
                6: begin a = BYTE_COUNT_EXPECTED; f = BYTE_COUNT_EXPECTED; end
                default: begin
                    a = 8'($urandom_range(0, 255));
                    f = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(REG_SLAVE_ADDRESS, a);
            write_reg(REG_EXPECTED_FUNCTION, f);
            rx_idle_on   = (p % 3 != 2) && (p < PHASE_COUNT - 1);
            res_stall_on = (p % 4 != 3) && (p < PHASE_COUNT - 1);
            if (p == 0) send_byte(cfg_func);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_byte(8'($urandom_range(0, 255)));
                    sent++;
                end
                send_random_reply();
                sent += FRAME_BYTES;
            end
            wait_drained();
        end

        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mbrx_pkg.sv
src/mbrx_crc.sv
src/mbrx_cfg.sv
src/mbrx_frame.sv
src/modbus_response_frame_receiver.sv
tb/tb.sv
